[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define DBSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define DBSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/dbsc_pkg.sv]
package dbsc_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned CfgWidth   = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_SKIP_A     = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_SKIP_B     = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_LIMIT      = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CFG_REPORT_MODE = 2'd3;

  localparam logic [1:0] MODE_SILENT = 2'd0;
  localparam logic [1:0] MODE_FIRST  = 2'd1;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_ALL,
    PH_DONE
  } dbsc_phase_e;

  typedef enum logic [2:0] {
    KIND_FINISHED,
    KIND_DIFF,
    KIND_A_END,
    KIND_B_END,
    KIND_A_END_SKIP,
    KIND_B_END_SKIP
  } dbsc_kind_e;

  typedef struct packed {
    logic [7:0] a_value;
    logic       a_present;
    logic       a_ended;
    logic [7:0] b_value;
    logic       b_present;
    logic       b_ended;
  } dbsc_in_t;

  typedef struct packed {
    logic [2:0]  report_kind;
    logic        streams_differ;
    logic        finished;
    logic [31:0] a_position;
    logic [31:0] a_line_number;
    logic [31:0] b_position;
    logic [31:0] b_line_number;
    logic [7:0]  a_byte_seen;
    logic [7:0]  b_byte_seen;
  } dbsc_out_t;

endpackage

[sv/dbsc_in_stage.sv]
module dbsc_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dbsc_pkg::dbsc_in_t in_data_i,
  input  logic               advance_i,
  output logic               item_valid_o,
  output dbsc_pkg::dbsc_in_t item_o
);
  import dbsc_pkg::*;

  logic     valid_d, valid_q;
  dbsc_in_t data_q;
  logic     accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign valid_d    = accept || (valid_q && !advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

[sv/dbsc_engine.sv]
module dbsc_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [dbsc_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [dbsc_pkg::CfgWidth-1:0]      cfg_wdata_i,
  input  logic                               fire_i,
  input  dbsc_pkg::dbsc_in_t                 item_i,
  output logic                               res_valid_o,
  output dbsc_pkg::dbsc_out_t                res_o
);
  import dbsc_pkg::*;

  `include "assert_macros.svh"

  typedef struct packed {
    logic       emit;
    logic       fin;
    dbsc_kind_e kind;
    logic       goto_all;
    logic       set_differ;
    logic       take_a;
    logic       take_b;
    logic       dec_a;
    logic       dec_b;
    logic       tick;
  } dbsc_dec_t;

  logic [31:0] skip_cfg_a_q, skip_cfg_b_q, limit_cfg_q;
  logic [1:0]  mode_q;

  dbsc_phase_e phase_d, phase_q;
  logic [31:0] skip_left_a_d, skip_left_a_q, skip_left_b_d, skip_left_b_q;
  logic [31:0] pairs_left_d, pairs_left_q;
  logic [CountWidth-1:0] count_a_d, count_a_q, count_b_d, count_b_q;
  logic [CountWidth-1:0] lines_a_d, lines_a_q, lines_b_d, lines_b_q;
  logic differ_d, differ_q;

  logic [31:0] sla, slb, pl;
  logic        silent, all_mode, skipping, na, nb, ea, eb, same, hit;
  dbsc_phase_e phase_eff;
  dbsc_dec_t   dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_cfg_a_q <= '0;
      skip_cfg_b_q <= '0;
      limit_cfg_q  <= '0;
      mode_q       <= MODE_FIRST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SKIP_A:      skip_cfg_a_q <= cfg_wdata_i;
        CFG_SKIP_B:      skip_cfg_b_q <= cfg_wdata_i;
        CFG_LIMIT:       limit_cfg_q  <= cfg_wdata_i;
        CFG_REPORT_MODE: mode_q       <= cfg_wdata_i[1:0];
      endcase
    end
  end

  assign sla       = (phase_q == PH_IDLE) ? skip_cfg_a_q : skip_left_a_q;
  assign slb       = (phase_q == PH_IDLE) ? skip_cfg_b_q : skip_left_b_q;
  assign pl        = (phase_q == PH_IDLE) ? limit_cfg_q : pairs_left_q;
  assign phase_eff = (phase_q == PH_IDLE) ? PH_RUN : phase_q;
  assign silent    = (mode_q == MODE_SILENT);
  assign all_mode  = mode_q[1];
  assign na        = (sla != '0);
  assign nb        = (slb != '0);
  assign skipping  = (phase_eff == PH_RUN) && (na || nb);
  assign ea        = skipping ? (na && item_i.a_ended) : item_i.a_ended;
  assign eb        = skipping ? (nb && item_i.b_ended) : item_i.b_ended;
  assign same      = (ea && eb) || (!ea && !eb && item_i.a_value == item_i.b_value);
  assign hit       = (pl == 32'd1);

  always_comb begin
    dec = '0;
    dec.kind = KIND_FINISHED;
    if (phase_q != PH_DONE) begin
      if (skipping) begin
        if (!((na && !item_i.a_present) || (nb && !item_i.b_present))) begin
          dec.take_a = na && !ea;
          dec.take_b = nb && !eb;
          if (ea && eb) begin
            dec.emit = 1'b1;
            dec.fin  = 1'b1;
          end else if (ea) begin
            dec.set_differ = 1'b1;
            dec.emit = 1'b1;
            dec.fin  = 1'b1;
            dec.kind = silent ? KIND_FINISHED : KIND_A_END_SKIP;
          end else if (eb) begin
            dec.set_differ = 1'b1;
            dec.emit = 1'b1;
            dec.fin  = 1'b1;
            dec.kind = silent ? KIND_FINISHED : KIND_B_END_SKIP;
          end else begin
            dec.dec_a = na;
            dec.dec_b = nb;
          end
        end
      end else if (item_i.a_present && item_i.b_present) begin
        dec.take_a = !ea;
        dec.take_b = !eb;
        if (phase_eff == PH_RUN) begin
          if (same) begin
            dec.tick = 1'b1;
            dec.emit = hit || ea;
            dec.fin  = hit || ea;
          end else begin
            dec.set_differ = 1'b1;
            dec.emit = 1'b1;
            if (ea) begin
              dec.fin  = 1'b1;
              dec.kind = silent ? KIND_FINISHED : KIND_A_END;
            end else if (eb) begin
              dec.fin  = 1'b1;
              dec.kind = silent ? KIND_FINISHED : KIND_B_END;
            end else if (silent) begin
              dec.fin  = 1'b1;
            end else if (!all_mode) begin
              dec.fin  = 1'b1;
              dec.kind = KIND_DIFF;
            end else begin
              dec.goto_all = 1'b1;
              dec.tick = 1'b1;
              dec.fin  = hit;
              dec.kind = KIND_DIFF;
            end
          end
        end else begin
          if (ea || eb) begin
            dec.emit = 1'b1;
            dec.fin  = 1'b1;
            dec.kind = (ea && eb) ? KIND_FINISHED : (ea ? KIND_A_END : KIND_B_END);
          end else begin
            dec.tick = 1'b1;
            if (item_i.a_value != item_i.b_value) begin
              dec.emit = 1'b1;
              dec.fin  = hit;
              dec.kind = KIND_DIFF;
            end else begin
              dec.emit = hit;
              dec.fin  = hit;
            end
          end
        end
      end
    end
  end

  always_comb begin
    phase_d = phase_q;
    if (fire_i) begin
      if (dec.emit && dec.fin) begin
        phase_d = PH_DONE;
      end else if (dec.goto_all) begin
        phase_d = PH_ALL;
      end else if (phase_q == PH_IDLE) begin
        phase_d = PH_RUN;
      end
    end
  end

  always_comb begin
    skip_left_a_d = sla - {31'd0, dec.dec_a};
    skip_left_b_d = slb - {31'd0, dec.dec_b};
    pairs_left_d  = (dec.tick && pl != '0) ? pl - 32'd1 : pl;
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    lines_a_d = lines_a_q;
    lines_b_d = lines_b_q;
    if (dec.take_a && count_a_q != '1) begin
      count_a_d = count_a_q + CountWidth'(1);
    end
    if (dec.take_a && item_i.a_value == NEWLINE_BYTE && lines_a_q != '1) begin
      lines_a_d = lines_a_q + CountWidth'(1);
    end
    if (dec.take_b && count_b_q != '1) begin
      count_b_d = count_b_q + CountWidth'(1);
    end
    if (dec.take_b && item_i.b_value == NEWLINE_BYTE && lines_b_q != '1) begin
      lines_b_d = lines_b_q + CountWidth'(1);
    end
    differ_d = differ_q || dec.set_differ;
  end

  always_comb begin
    res_valid_o          = fire_i && dec.emit;
    res_o.report_kind    = dec.kind;
    res_o.streams_differ = differ_d;
    res_o.finished       = dec.fin;
    res_o.a_position     = 32'(count_a_d);
    res_o.a_line_number  = 32'(lines_a_d);
    res_o.b_position     = 32'(count_b_d);
    res_o.b_line_number  = 32'(lines_b_d);
    res_o.a_byte_seen    = (dec.kind == KIND_DIFF) ? item_i.a_value : 8'd0;
    res_o.b_byte_seen    = (dec.kind == KIND_DIFF) ? item_i.b_value : 8'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      skip_left_a_q <= '0;
      skip_left_b_q <= '0;
      pairs_left_q  <= '0;
      count_a_q     <= '0;
      count_b_q     <= '0;
      lines_a_q     <= CountWidth'(1);
      lines_b_q     <= CountWidth'(1);
      differ_q      <= 1'b0;
    end else if (fire_i) begin
      phase_q       <= phase_d;
      skip_left_a_q <= skip_left_a_d;
      skip_left_b_q <= skip_left_b_d;
      pairs_left_q  <= pairs_left_d;
      count_a_q     <= count_a_d;
      count_b_q     <= count_b_d;
      lines_a_q     <= lines_a_d;
      lines_b_q     <= lines_b_d;
      differ_q      <= differ_d;
    end
  end

  `DBSC_ASSERT_NOW(a_done_silent, phase_q == PH_DONE, !res_valid_o, "result after finish")
  `DBSC_ASSERT_NEXT(a_fin_done, res_valid_o && res_o.finished, phase_q == PH_DONE, "finish not held")
  `DBSC_ASSERT_NEXT(a_differ_sticky, differ_q, differ_q, "verdict dropped")
  `DBSC_ASSERT_NOW(a_lines_nonzero, 1'b1, lines_a_q != '0 && lines_b_q != '0, "line count zero")

endmodule

[sv/dbsc_out_stage.sv]
module dbsc_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  input  dbsc_pkg::dbsc_out_t res_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dbsc_pkg::dbsc_out_t out_data_o
);
  import dbsc_pkg::*;

  logic      valid_d, valid_q;
  dbsc_out_t data_q;

  assign room_o  = !valid_q || !out_stall_i;
  assign valid_d = room_o ? res_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (room_o && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

[sv/dual_byte_stream_comparator_top.sv]
// channel   direction  handshake              payload
// in        input      in_valid_i/in_stall_o  in_data_i   (dbsc_in_t)
// out       output     out_valid_o/out_stall_i out_data_o (dbsc_out_t)
// cfg       input      cfg_we_i               cfg_idx_i, cfg_wdata_i
//
// One transaction per cycle while in_stall_o is low: input register, one
// pass of compare and counter logic, then the result register.
// Reset is asynchronous, active low; positions and phase clear, line counts
// go to 1, registers load defaults, skip and limit load at first transaction.
// A stalled result holds in the result register while the input register
// still takes a transaction; the input stalls once both are full.
module dual_byte_stream_comparator_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  dbsc_pkg::dbsc_in_t               in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output dbsc_pkg::dbsc_out_t              out_data_o,
  input  logic                             cfg_we_i,
  input  logic [dbsc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [dbsc_pkg::CfgWidth-1:0]    cfg_wdata_i
);
  import dbsc_pkg::*;

  logic      item_valid, room, fire, res_valid;
  dbsc_in_t  item;
  dbsc_out_t res;

  assign fire = item_valid && room;

  dbsc_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .advance_i    (room),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  dbsc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  dbsc_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

[verif/dbsc_report_checker.sv]
`timescale 1ns / 1ps

module dbsc_report_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  dbsc_pkg::dbsc_in_t               in_data_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  dbsc_pkg::dbsc_out_t              out_data_i,
  input  logic                             cfg_we_i,
  input  logic [dbsc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [dbsc_pkg::CfgWidth-1:0]    cfg_wdata_i,
  output int                               mismatches_o,
  output int                               pending_o
);
  import dbsc_pkg::*;

  localparam logic [31:0] COUNT_TOP = '1;

  logic [31:0] skip_cfg_a, skip_cfg_b, limit_cfg;
  logic [1:0]  mode_cfg;
  dbsc_phase_e phase;
  logic [31:0] skip_left_a, skip_left_b, pairs_left;
  logic [31:0] pos_a, pos_b, line_a, line_b;
  logic        differ;
  dbsc_out_t   expected_reports[$];
  int          mismatch_count;
  int          pending_count;

  assign mismatches_o = mismatch_count;
  assign pending_o    = pending_count;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == COUNT_TOP) ? v : v + 32'd1;
  endfunction

  // consume one pair of the limit; true when it runs out
  function automatic logic last_pair();
    if (pairs_left == '0) return 1'b0;
    pairs_left = pairs_left - 32'd1;
    return pairs_left == '0;
  endfunction

  task automatic take_a(logic [7:0] v);
    pos_a = sat_inc(pos_a);
    if (v == NEWLINE_BYTE) line_a = sat_inc(line_a);
  endtask

  task automatic take_b(logic [7:0] v);
    pos_b = sat_inc(pos_b);
    if (v == NEWLINE_BYTE) line_b = sat_inc(line_b);
  endtask

  task automatic emit(dbsc_kind_e kind, logic fin, logic [7:0] byte_a, logic [7:0] byte_b);
    dbsc_out_t r;
    r.report_kind    = kind;
    r.streams_differ = differ;
    r.finished       = fin;
    r.a_position     = pos_a;
    r.a_line_number  = line_a;
    r.b_position     = pos_b;
    r.b_line_number  = line_b;
    r.a_byte_seen    = byte_a;
    r.b_byte_seen    = byte_b;
    expected_reports.push_back(r);
    if (fin) phase = PH_DONE;
  endtask

  task automatic compare_transaction(dbsc_in_t t);
    logic silent, all_mode, need_a, need_b, end_a, end_b, hit, same;
    silent   = (mode_cfg == MODE_SILENT);
    all_mode = (mode_cfg > MODE_FIRST);
    if (phase == PH_DONE) return;
    if (phase == PH_IDLE) begin
      skip_left_a = skip_cfg_a;
      skip_left_b = skip_cfg_b;
      pairs_left  = limit_cfg;
      phase       = PH_RUN;
    end
    if (phase == PH_RUN && (skip_left_a != '0 || skip_left_b != '0)) begin
      need_a = (skip_left_a != '0);
      need_b = (skip_left_b != '0);
      if ((need_a && !t.a_present) || (need_b && !t.b_present)) return;
      end_a = need_a && t.a_ended;
      end_b = need_b && t.b_ended;
      if (need_a && !end_a) take_a(t.a_value);
      if (need_b && !end_b) take_b(t.b_value);
      if (end_a && end_b) begin
        emit(KIND_FINISHED, 1'b1, '0, '0);
      end else if (end_a) begin
        differ = 1'b1;
        emit(silent ? KIND_FINISHED : KIND_A_END_SKIP, 1'b1, '0, '0);
      end else if (end_b) begin
        differ = 1'b1;
        emit(silent ? KIND_FINISHED : KIND_B_END_SKIP, 1'b1, '0, '0);
      end else begin
        if (need_a) skip_left_a = skip_left_a - 32'd1;
        if (need_b) skip_left_b = skip_left_b - 32'd1;
      end
      return;
    end
    if (!t.a_present || !t.b_present) return;
    end_a = t.a_ended;
    end_b = t.b_ended;
    if (!end_a) take_a(t.a_value);
    if (!end_b) take_b(t.b_value);
    if (phase == PH_RUN) begin
      same = (end_a && end_b) || (!end_a && !end_b && t.a_value == t.b_value);
      if (same) begin
        hit = last_pair();
        if (hit || end_a) emit(KIND_FINISHED, 1'b1, '0, '0);
      end else begin
        differ = 1'b1;
        if (end_a) begin
          emit(silent ? KIND_FINISHED : KIND_A_END, 1'b1, '0, '0);
        end else if (end_b) begin
          emit(silent ? KIND_FINISHED : KIND_B_END, 1'b1, '0, '0);
        end else if (silent) begin
          emit(KIND_FINISHED, 1'b1, '0, '0);
        end else if (!all_mode) begin
          emit(KIND_DIFF, 1'b1, t.a_value, t.b_value);
        end else begin
          phase = PH_ALL;
          hit   = last_pair();
          emit(KIND_DIFF, hit, t.a_value, t.b_value);
        end
      end
    end else begin
      if (end_a && end_b) begin
        emit(KIND_FINISHED, 1'b1, '0, '0);
      end else if (end_a) begin
        emit(KIND_A_END, 1'b1, '0, '0);
      end else if (end_b) begin
        emit(KIND_B_END, 1'b1, '0, '0);
      end else begin
        hit = last_pair();
        if (t.a_value != t.b_value) emit(KIND_DIFF, hit, t.a_value, t.b_value);
        else if (hit) emit(KIND_FINISHED, 1'b1, '0, '0);
      end
    end
  endtask

  task automatic note(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch in %s: expected 0x%0h, got 0x%0h", what, want, got);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) note(what, want, got);
  endtask

  task automatic check_report(dbsc_out_t got);
    dbsc_out_t want;
    if (expected_reports.size() == 0) begin
      note("report with none pending, report_kind", '0, 32'(got.report_kind));
      return;
    end
    want = expected_reports.pop_front();
    check_field("report_kind", 32'(want.report_kind), 32'(got.report_kind));
    check_field("streams_differ", 32'(want.streams_differ), 32'(got.streams_differ));
    check_field("finished", 32'(want.finished), 32'(got.finished));
    check_field("a_position", want.a_position, got.a_position);
    check_field("a_line_number", want.a_line_number, got.a_line_number);
    check_field("b_position", want.b_position, got.b_position);
    check_field("b_line_number", want.b_line_number, got.b_line_number);
    check_field("a_byte_seen", 32'(want.a_byte_seen), 32'(got.a_byte_seen));
    check_field("b_byte_seen", 32'(want.b_byte_seen), 32'(got.b_byte_seen));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_cfg_a     = '0;
      skip_cfg_b     = '0;
      limit_cfg      = '0;
      mode_cfg       = MODE_FIRST;
      phase          = PH_IDLE;
      skip_left_a    = '0;
      skip_left_b    = '0;
      pairs_left     = '0;
      pos_a          = '0;
      pos_b          = '0;
      line_a         = 32'd1;
      line_b         = 32'd1;
      differ         = 1'b0;
      expected_reports.delete();
      mismatch_count = 0;
      pending_count <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_report(out_data_i);
      if (in_valid_i && !in_stall_i) compare_transaction(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SKIP_A:      skip_cfg_a = cfg_wdata_i;
          CFG_SKIP_B:      skip_cfg_b = cfg_wdata_i;
          CFG_LIMIT:       limit_cfg  = cfg_wdata_i;
          CFG_REPORT_MODE: mode_cfg   = cfg_wdata_i[1:0];
          default: ;
        endcase
      end
      pending_count <= expected_reports.size();
    end
  end

endmodule

[verif/tb_dual_byte_stream_comparator_top.sv]
`timescale 1ns / 1ps

module tb_dual_byte_stream_comparator_top;
  import dbsc_pkg::*;

  localparam int LATENCY         = 4;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int PAIRS_UNLIMITED = 800;
  localparam int TAIL_PAIRS      = 40;
  localparam logic [1:0] MODE_ALL     = 2'd2;
  localparam logic [1:0] MODE_ALL_ALT = 2'd3;

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  dbsc_in_t               in_data_i;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  dbsc_out_t              out_data_o;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0]    cfg_wdata_i;

  int          mismatches;
  int          pending;
  int          cycles     = 0;
  int          burst_left = 0;
  int          stall_hold = 0;
  int          pairs_sent = 0;
  logic        counting_pairs = 1'b0;
  int unsigned limit_pick;
  int unsigned pair_target;

  always #2 clk_i = ~clk_i;

  dual_byte_stream_comparator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  dbsc_report_checker report_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // alternate free and stalled stretches on the result side
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 4);
    end else if ($urandom_range(0, 99) < 40) begin
      out_stall_i <= 1'b1;
      stall_hold  <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    end
  end

  function automatic dbsc_in_t mk_item(logic [7:0] av, logic ap, logic ae,
                                       logic [7:0] bv, logic bp, logic be);
    dbsc_in_t t;
    t.a_value   = av;
    t.a_present = ap;
    t.a_ended   = ae;
    t.b_value   = bv;
    t.b_present = bp;
    t.b_ended   = be;
    return t;
  endfunction

  function automatic logic [7:0] pick_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return NEWLINE_BYTE;
    if (r < 35) return 8'h00;
    if (r < 45) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic dbsc_in_t random_item();
    dbsc_in_t    t;
    logic [7:0]  av;
    int unsigned shape;
    av = pick_byte();
    if ($urandom_range(0, 99) < 85)
      return mk_item(av, 1'b1, 1'b0, ($urandom_range(0, 1) == 0) ? av : pick_byte(), 1'b1, 1'b0);
    t = dbsc_in_t'($urandom());
    shape = $urandom_range(0, 2);
    t.a_present = (shape == 0);
    t.b_present = (shape == 1);
    return t;
  endfunction

  task automatic send(dbsc_in_t item);
    int gap;
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      burst_left = $urandom_range(20, 60);
      gap = 0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else gap = $urandom_range(5, 30);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    if (counting_pairs && item.a_present && item.b_present && !item.a_ended && !item.b_ended)
      pairs_sent++;
  endtask

  // drop valid and wait until every report is back and the pipe is empty
  task automatic settle();
    in_valid_i <= 1'b0;
    repeat (LATENCY) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgWidth-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = CFG_SKIP_A;
    cfg_wdata_i = '0;
    limit_pick  = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(600, 760);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_SKIP_A, 32'd3);
    write_reg(CFG_SKIP_B, 32'd2);
    write_reg(CFG_LIMIT, limit_pick);
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_FIRST});

    send(mk_item(8'hFF, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0));
    send(mk_item(8'h0A, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0));
    send(mk_item(8'h41, 1'b1, 1'b0, 8'hFF, 1'b1, 1'b0));
    send(mk_item(8'h12, 1'b0, 1'b0, 8'h34, 1'b1, 1'b1));
    send(mk_item(8'h0A, 1'b1, 1'b0, 8'h77, 1'b1, 1'b1));
    counting_pairs = 1'b1;
    send(mk_item(8'h0A, 1'b1, 1'b0, 8'h0A, 1'b1, 1'b0));
    send(mk_item(8'h33, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0));
    send(mk_item(8'h00, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0));
    send(mk_item(8'hFF, 1'b1, 1'b0, 8'hFF, 1'b1, 1'b0));

    settle();
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_SILENT});
    send(mk_item(8'h55, 1'b1, 1'b0, 8'h55, 1'b1, 1'b0));
    send(mk_item(8'h00, 1'b0, 1'b1, 8'h66, 1'b1, 1'b1));

    settle();
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_ALL_ALT});
    send(mk_item(8'h01, 1'b1, 1'b0, 8'h02, 1'b1, 1'b0));
    send(mk_item(8'h0A, 1'b1, 1'b0, 8'h0A, 1'b1, 1'b0));
    send(mk_item(8'h00, 1'b1, 1'b0, 8'hFF, 1'b1, 1'b0));

    settle();
    write_reg(CFG_SKIP_A, 32'hFFFF_FFFF);
    write_reg(CFG_SKIP_B, 32'd0);
    write_reg(CFG_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_SILENT});
    write_reg(CFG_REPORT_MODE, {30'd0, MODE_ALL});
    send(mk_item(8'hFF, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0));

    pair_target = (limit_pick == 0) ? PAIRS_UNLIMITED : limit_pick + TAIL_PAIRS;
    while (pairs_sent < pair_target) send(random_item());
    case ($urandom_range(0, 2))
      0: send(mk_item(pick_byte(), 1'b1, 1'b1, pick_byte(), 1'b1, 1'b1));
      1: send(mk_item(pick_byte(), 1'b1, 1'b1, pick_byte(), 1'b1, 1'b0));
      default: send(mk_item(pick_byte(), 1'b1, 1'b0, pick_byte(), 1'b1, 1'b1));
    endcase

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/dbsc_pkg.sv
sv/dbsc_in_stage.sv
sv/dbsc_engine.sv
sv/dbsc_out_stage.sv
sv/dual_byte_stream_comparator_top.sv
verif/dbsc_report_checker.sv
verif/tb_dual_byte_stream_comparator_top.sv
